[hdl/rqps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqps_pkg
// Request and response types shared by the ready queue and its checker.
// ----------------------------------------------------------------------------
package rqps_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 6;
  localparam int CNT_W  = 7;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [ID_W-1:0]     proc_id;
    logic [PRIO_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic                found;
    logic                overflow;
    logic [CNT_W-1:0]    entry_count;
  } rsp_t;

endpackage

[hdl/ready_queue_priority_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_priority_select
// Bounded ready queue; insert appends an entry, remove returns the latest
// entry among those of highest priority and closes the gap.
// ----------------------------------------------------------------------------
// Insert, and remove on an empty queue, go straight to the response.
// Remove with N entries held and the winner in slot B: a scan of all N slots,
// then a shift of the entries behind B down by one; one memory read per cycle
// for the scan (N) and the shift (N - B - 1).
// One request at a time; the response register frees the sequencer.
// Synchronous reset empties the queue and drops any pending response.
// ----------------------------------------------------------------------------
module ready_queue_priority_select #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  rqps_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output rqps_pkg::rsp_t  rsp
);

  import rqps_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     didx;
  logic              dvalid;
  logic [CW-1:0]     best_idx;
  logic [ID_W-1:0]   best_id;
  logic [PRIO_W-1:0] best_prio;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic              res_found;
  logic              res_over;

  entry_t            mem [CAPACITY];
  entry_t            rd_data;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  entry_t            mem_wd;

  logic              accept;
  logic              full;
  logic              issue;
  logic              take;
  logic              scan_last;
  logic [CW-1:0]     best_idx_next;
  logic [ID_W-1:0]   best_id_next;
  logic [PRIO_W-1:0] best_prio_next;
  logic [CW-1:0]     shift_wa;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(CAPACITY));
  assign issue     = (idx < count);
  assign rd_addr   = idx[AW-1:0];
  assign shift_wa  = didx - CW'(1);

  assign take           = (didx == '0) || (rd_data.prio >= best_prio);
  assign scan_last      = dvalid && (didx == count - CW'(1));
  assign best_idx_next  = take ? didx : best_idx;
  assign best_id_next   = take ? rd_data.id : best_id;
  assign best_prio_next = take ? rd_data.prio : best_prio;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = count[AW-1:0];
    mem_wd = '{id: req.proc_id, prio: req.priority_req};
    if (state == ST_IDLE && accept && req.func == FUNC_INSERT && !full) begin
      mem_we = 1'b1;
    end else if (state == ST_SHIFT && dvalid) begin
      mem_we = 1'b1;
      mem_wa = shift_wa[AW-1:0];
      mem_wd = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      dvalid    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (state == ST_DONE) || (rsp_valid && !rsp_ready);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_id    <= '0;
            res_prio  <= '0;
            res_found <= 1'b0;
            res_over  <= (req.func == FUNC_INSERT) && full;
            idx       <= '0;
            dvalid    <= 1'b0;
            if (req.func == FUNC_INSERT) begin
              if (!full) begin
                count <= count + CW'(1);
              end
              state <= ST_DONE;
            end else if (count == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            idx  <= idx + CW'(1);
            didx <= idx;
          end
          dvalid <= issue;
          if (dvalid) begin
            best_idx  <= best_idx_next;
            best_id   <= best_id_next;
            best_prio <= best_prio_next;
          end
          if (scan_last) begin
            idx   <= best_idx_next + CW'(1);
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (issue) begin
            idx  <= idx + CW'(1);
            didx <= idx;
          end
          dvalid <= issue;
          if (!issue && !dvalid) begin
            count     <= count - CW'(1);
            res_id    <= best_id;
            res_prio  <= best_prio;
            res_found <= 1'b1;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.out_id       <= res_id;
            rsp.out_priority <= res_prio;
            rsp.found        <= res_found;
            rsp.overflow     <= res_over;
            rsp.entry_count  <= CNT_W'(count);
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/rqps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqps_checker
// Port-level checks for the ready queue, bound to the ready queue module.
// ----------------------------------------------------------------------------
module rqps_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input rqps_pkg::req_t  req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input rqps_pkg::rsp_t  rsp
);

  import rqps_pkg::*;

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a request is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.found && rsp.overflow))
    else $error("response both found and overflow");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.out_id == '0 && rsp.out_priority == '0)
    else $error("response without entry carries data");

endmodule

bind ready_queue_priority_select rqps_checker u_rqps_checker (.*);

[sim/ready_queue_priority_select_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_priority_select_tb
// Self-checking bench for the priority ready queue. A short table of
// requests covers the empty and extreme cases and ties among equal
// priorities. Random fill, drain and mixed phases follow and drive the queue
// to full and back. Both sides idle at random, and the response side holds
// off once for a long stretch. Every response is compared with the expected
// value from the table or with a queue model kept in insertion order.
// ----------------------------------------------------------------------------
module ready_queue_priority_select_tb;
  import rqps_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int MAX_GAP        = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 200;
  localparam int DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    req_t rq;
    logic typed;
    rsp_t want;
  } step_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } load_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  entry_t ready_entries[$];
  rsp_t   pending_rsps[$];
  step_t  directed_steps[$];
  int     mismatches = 0;
  int     req_total = 0;
  int     rsp_total = 0;
  bit     req_quiet = 1'b0;
  bit     rsp_quiet = 1'b0;

  ready_queue_priority_select #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t   res;
    entry_t e;
    int     best;
    int     i;
    res = '0;
    if (r.func == FUNC_INSERT) begin
      if (ready_entries.size() >= QUEUE_DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        e.id   = r.proc_id;
        e.prio = r.priority_req;
        ready_entries.push_back(e);
      end
    end else if (ready_entries.size() > 0) begin
      best = 0;
      // latest among equal priorities wins
      for (i = 1; i < ready_entries.size(); i++) begin
        if (ready_entries[i].prio >= ready_entries[best].prio) best = i;
      end
      res.out_id       = ready_entries[best].id;
      res.out_priority = ready_entries[best].prio;
      res.found        = 1'b1;
      ready_entries.delete(best);
    end
    res.entry_count = CNT_W'(ready_entries.size());
    return res;
  endfunction

  function automatic step_t mk_step(func_t f, logic [ID_W-1:0] id, logic [PRIO_W-1:0] p,
                                    logic typed, logic [ID_W-1:0] w_id,
                                    logic [PRIO_W-1:0] w_prio, logic w_found,
                                    logic w_over, logic [CNT_W-1:0] w_cnt);
    step_t s;
    s.rq.func              = f;
    s.rq.proc_id           = id;
    s.rq.priority_req      = p;
    s.typed                = typed;
    s.want.out_id          = w_id;
    s.want.out_priority    = w_prio;
    s.want.found           = w_found;
    s.want.overflow        = w_over;
    s.want.entry_count     = w_cnt;
    return s;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic offer(input req_t r, input logic typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    if (req_total % 50 == 0) req_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_gap(req_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    predicted = apply_request(r);
    pending_rsps.push_back(typed ? want : predicted);
    req_total++;
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t exp_rsp;
    if (pending_rsps.size() == 0) begin
      $display("%0t: unexpected response %h", $time, got);
      mismatches++;
    end else begin
      exp_rsp = pending_rsps.pop_front();
      if (got.out_id !== exp_rsp.out_id) begin
        $display("%0t: out_id expected %h actual %h", $time, exp_rsp.out_id, got.out_id);
        mismatches++;
      end
      if (got.out_priority !== exp_rsp.out_priority) begin
        $display("%0t: out_priority expected %0d actual %0d", $time,
                 exp_rsp.out_priority, got.out_priority);
        mismatches++;
      end
      if (got.found !== exp_rsp.found) begin
        $display("%0t: found expected %b actual %b", $time, exp_rsp.found, got.found);
        mismatches++;
      end
      if (got.overflow !== exp_rsp.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, exp_rsp.overflow,
                 got.overflow);
        mismatches++;
      end
      if (got.entry_count !== exp_rsp.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 exp_rsp.entry_count, got.entry_count);
        mismatches++;
      end
    end
  endtask

  // response side
  initial begin
    int wait_cycles;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_total % 50 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      wait_cycles = (rsp_total == HOLD_AT) ? HOLD_CYCLES : draw_gap(rsp_quiet);
      if (wait_cycles > 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_response(rsp);
      rsp_total++;
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_t        r;
    load_phase_t phase;
    int          phase_len;
    int          insert_odds;
    int          sent_random;
    bit          narrow;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    directed_steps = '{
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b1, 16'h0000, 6'd0,  1'b0, 1'b0, 7'd0),
      mk_step(FUNC_INSERT, 16'hFFFF, 6'd63, 1'b1, 16'h0000, 6'd0,  1'b0, 1'b0, 7'd1),
      mk_step(FUNC_REMOVE, 16'hFFFF, 6'd63, 1'b1, 16'hFFFF, 6'd63, 1'b1, 1'b0, 7'd0),
      mk_step(FUNC_INSERT, 16'h0000, 6'd0,  1'b1, 16'h0000, 6'd0,  1'b0, 1'b0, 7'd1),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b1, 16'h0000, 6'd0,  1'b1, 1'b0, 7'd0),
      mk_step(FUNC_INSERT, 16'h1111, 6'd5,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h2222, 6'd5,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h3333, 6'd5,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h4444, 6'd2,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h5555, 6'd40, 1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'hAAAA, 6'd21, 1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h5555, 6'd42, 1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h6666, 6'd5,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'hAAAA, 6'd63, 1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_INSERT, 16'h5555, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'h0000, 6'd0,  1'b0, '0, '0, 1'b0, 1'b0, '0),
      mk_step(FUNC_REMOVE, 16'hFFFF, 6'd63, 1'b1, 16'h0000, 6'd0,  1'b0, 1'b0, 7'd0)
    };
    foreach (directed_steps[k]) begin
      offer(directed_steps[k].rq, directed_steps[k].typed, directed_steps[k].want);
    end

    // fill past capacity first, then load phases chosen at random
    sent_random = 0;
    phase       = PH_FILL;
    phase_len   = 96;
    while (sent_random < RANDOM_ITEMS) begin
      case (phase)
        PH_FILL:  insert_odds = 15;
        PH_DRAIN: insert_odds = 1;
        default:  insert_odds = 8;
      endcase
      narrow = ($urandom_range(0, 2) != 0);
      repeat (phase_len) begin
        r.func         = ($urandom_range(0, 15) < insert_odds) ? FUNC_INSERT : FUNC_REMOVE;
        r.proc_id      = ID_W'($urandom);
        r.priority_req = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        offer(r, 1'b0, '0);
        sent_random++;
      end
      phase     = load_phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 100);
    end
    req_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rqps_pkg.sv
hdl/ready_queue_priority_select.sv
hdl/rqps_checker.sv
sim/ready_queue_priority_select_tb.sv
